>>> hw/rtl/xdbt_pkg.sv
// Package for the XOR-distance bucket table.
// Holds widths, status codes and default parameters; no dependencies.
`timescale 1ns / 1ps
package xdbt_pkg;
  localparam int unsigned HashW = 64;
  localparam int unsigned AddrW = 48;
  localparam int unsigned HashBitsDefault = 64;
  localparam int unsigned BucketSizeDefault = 8;
  localparam int unsigned FillW = 4;
  localparam int unsigned IdxW = 6;

  typedef enum logic [1:0] {
    StIgnored = 2'd0,
    StMoved   = 2'd1,
    StInsert  = 2'd2,
    StEvict   = 2'd3
  } status_e;
endpackage

>>> hw/rtl/xor_distance_bucket_table.sv
// Top level of the XOR-distance bucket table (k-bucket routing table).
// Depends on xdbt_pkg; holds the entry memory and the bucket fill registers.
`timescale 1ns / 1ps
//
//  channel  | direction | handshake             | payload
//  ---------+-----------+-----------------------+---------------------------------
//  cfg      | in        | cfg_valid_i/ready_o   | cfg_data_i = own_hash
//  s_axis   | in        | s_axis_tvalid/tready  | tdata: node_hash, node_address
//  m_axis   | out       | m_axis_tvalid/tready  | tdata: status, bucket_index,
//           |           |                       |        evicted_hash, evicted_addr
//
// One word is handled at a time. With a ready receiver, a word that carries the
// own hash passes through the accepting cycle, the bucket pick, the result load
// and the wait in the output register; any other word also passes through the
// scan, the shift and the front write before the result load. The scan issues
// one read per slot to the single-port entry memory, whose data arrives in the
// next cycle, so it ends after the hit slot on a hit, after the last filled
// slot on a miss, and it issues no read in an empty bucket. The shift then moves
// each slot from the hit slot (or the tail) one place back, a read cycle followed
// by a write cycle. With eight slots the longest case is a full bucket with eviction.
// Reset clears the fill counts at once (flip-flops); the entry memory is never
// cleared. The result sits in an output register; the next word is accepted
// only once it has been taken, and a stalled receiver stalls the input.
module xor_distance_bucket_table #(
  parameter int unsigned HASH_BITS   = xdbt_pkg::HashBitsDefault,
  parameter int unsigned BUCKET_SIZE = xdbt_pkg::BucketSizeDefault
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [63:0]  cfg_data_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // node_hash[63:0], node_address[111:64]
  input  logic [111:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // status[1:0], bucket_index[7:2], evicted_hash[71:8], evicted_address[119:72]
  output logic [119:0] m_axis_tdata
);
  localparam int unsigned HW = xdbt_pkg::HashW;
  localparam int unsigned AW = xdbt_pkg::AddrW;
  localparam int unsigned FW = xdbt_pkg::FillW;
  localparam int unsigned IW = xdbt_pkg::IdxW;
  localparam int unsigned Depth = HASH_BITS * BUCKET_SIZE;
  localparam int unsigned MemAW = $clog2(Depth);
  localparam int unsigned BW = $clog2(HASH_BITS);
  localparam logic [HW-1:0] HashMask = {HW{1'b1}} >> (HW - HASH_BITS);
  localparam logic [FW-1:0] BSize = FW'(BUCKET_SIZE);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PICK  = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_SHRD  = 3'd3;
  localparam logic [2:0] S_SHWR  = 3'd4;
  localparam logic [2:0] S_FRONT = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  logic [2:0] state_q, state_d;
  logic [HW-1:0] own_q;
  logic [HW-1:0] h_q, x_q;
  logic [AW-1:0] a_q;
  logic [BW-1:0] b_q;
  logic [FW-1:0] fill_q, slot_q, dst_q;
  logic rd_pend_q;
  logic [FW-1:0] fill_r [HASH_BITS];
  logic [HW+AW-1:0] mem [Depth];
  logic [HW+AW-1:0] rdata_q;
  logic [1:0] st_q;
  logic [HW-1:0] ev_h_q;
  logic [AW-1:0] ev_a_q;
  logic out_v_q;

  logic mem_we, mem_re;
  logic [MemAW-1:0] mem_addr;
  logic [HW+AW-1:0] mem_wd;
  logic [BW-1:0] lz;
  logic [MemAW-1:0] base;

  assign cfg_ready_o = (state_q == S_IDLE) && !out_v_q;
  assign s_axis_tready = (state_q == S_IDLE) && !out_v_q && !cfg_valid_i;
  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata = {ev_a_q, ev_h_q, IW'(b_q), st_q};
  assign base = MemAW'(b_q) * MemAW'(BUCKET_SIZE);

  // Leading-one search is combinational on the registered XOR and is used in the bucket pick.
  always_comb begin
    lz = BW'(HASH_BITS - 1);
    for (int j = HASH_BITS - 1; j >= 0; j--) begin
      if (x_q[HASH_BITS - 1 - j]) lz = BW'(j);
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_addr] <= mem_wd;
    if (mem_re) rdata_q <= mem[mem_addr];
  end

  always_comb begin
    state_d = state_q;
    mem_we = 1'b0;
    mem_re = 1'b0;
    mem_addr = base + MemAW'(slot_q);
    mem_wd = rdata_q;
    unique case (state_q)
      S_IDLE: if (s_axis_tvalid && s_axis_tready) state_d = S_PICK;
      S_PICK: state_d = (x_q == '0) ? S_OUT : S_SCAN;
      S_SCAN: begin
        mem_re = slot_q < fill_q;
        if (rd_pend_q && rdata_q == {a_q, h_q}) state_d = S_SHRD;
        else if (!rd_pend_q && slot_q >= fill_q) state_d = S_SHRD;
      end
      S_SHRD: begin
        mem_addr = base + MemAW'(dst_q - 4'd1);
        mem_re = dst_q != '0;
        state_d = (dst_q == '0) ? S_FRONT : S_SHWR;
      end
      S_SHWR: begin
        mem_addr = base + MemAW'(dst_q);
        mem_we = 1'b1;
        state_d = S_SHRD;
      end
      S_FRONT: begin
        mem_addr = base;
        mem_we = 1'b1;
        mem_wd = {a_q, h_q};
        state_d = S_OUT;
      end
      S_OUT: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      own_q <= '0;
      out_v_q <= 1'b0;
      rd_pend_q <= 1'b0;
      for (int i = 0; i < HASH_BITS; i++) fill_r[i] <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) own_q <= cfg_data_i;
      if (out_v_q && m_axis_tready) out_v_q <= 1'b0;
      unique case (state_q)
        S_IDLE: if (s_axis_tvalid && s_axis_tready) begin
          h_q <= s_axis_tdata[HW-1:0] & HashMask;
          a_q <= s_axis_tdata[HW+AW-1:HW];
          x_q <= (s_axis_tdata[HW-1:0] ^ own_q) & HashMask;
          st_q <= xdbt_pkg::StIgnored;
          ev_h_q <= '0;
          ev_a_q <= '0;
          b_q <= '0;
        end
        S_PICK: begin
          b_q <= (x_q == '0) ? '0 : lz;
          fill_q <= (fill_r[lz] > BSize) ? BSize : fill_r[lz];
          slot_q <= '0;
          rd_pend_q <= 1'b0;
        end
        S_SCAN: begin
          rd_pend_q <= slot_q < fill_q;
          if (slot_q < fill_q) slot_q <= slot_q + 4'd1;
          if (rd_pend_q && rdata_q == {a_q, h_q}) begin
            st_q <= xdbt_pkg::StMoved;
            dst_q <= slot_q - 4'd1;
          end else if (!rd_pend_q && slot_q >= fill_q) begin
            if (fill_q >= BSize) begin
              st_q <= xdbt_pkg::StEvict;
              ev_h_q <= rdata_q[HW-1:0] & HashMask;
              ev_a_q <= rdata_q[HW+AW-1:HW];
              dst_q <= BSize - 4'd1;
              fill_r[b_q] <= BSize;
            end else begin
              st_q <= xdbt_pkg::StInsert;
              dst_q <= fill_q;
              fill_r[b_q] <= fill_q + 4'd1;
            end
          end
        end
        S_SHWR: dst_q <= dst_q - 4'd1;
        S_OUT: out_v_q <= 1'b1;
        default: ;
      endcase
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && !m_axis_tready |=> out_v_q && $stable(m_axis_tdata))
    else $error("result changed while stalled");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != S_IDLE |-> !s_axis_tready)
    else $error("input accepted while busy");
  a_no_wr_rd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_we && mem_re))
    else $error("memory read and write together");
  a_evict_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT && st_q == xdbt_pkg::StEvict) |-> fill_r[b_q] == BSize)
    else $error("eviction without a full bucket");
endmodule

>>> verif/route_table_checker.sv
// Checker for the XOR-distance bucket table: watches the config, node and result channels.
// It keeps its own copy of the routing table and compares every result word with its prediction.
// Depends on xdbt_pkg only.
`timescale 1ns / 1ps
module route_table_checker (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_valid_i,
  input  logic         cfg_ready_i,
  input  logic [63:0]  cfg_data_i,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  // node_hash[63:0], node_address[111:64]
  input  logic [111:0] s_axis_tdata,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // status[1:0], bucket_index[7:2], evicted_hash[71:8], evicted_address[119:72]
  input  logic [119:0] m_axis_tdata,
  output int           fail_count_o,
  output int           pending_o
);
  localparam int unsigned Buckets = xdbt_pkg::HashBitsDefault;
  localparam int unsigned Slots   = xdbt_pkg::BucketSizeDefault;

  typedef struct packed {
    logic [xdbt_pkg::AddrW-1:0] evicted_address;
    logic [xdbt_pkg::HashW-1:0] evicted_hash;
    logic [xdbt_pkg::IdxW-1:0]  bucket_index;
    xdbt_pkg::status_e          status;
  } route_result_t;

  logic [xdbt_pkg::HashW-1:0] own_hash_q;
  logic [xdbt_pkg::HashW-1:0] slot_hash [Buckets][Slots];
  logic [xdbt_pkg::AddrW-1:0] slot_addr [Buckets][Slots];
  int unsigned      fill_cnt  [Buckets];
  route_result_t    expected_routes [$];
  int               fail_count;

  assign fail_count_o = fail_count;
  assign pending_o    = expected_routes.size();

  // Updates the table for one offered node and returns the result it causes.
  function automatic route_result_t add_node(input logic [xdbt_pkg::HashW-1:0] h,
                                             input logic [xdbt_pkg::AddrW-1:0] a);
    route_result_t    r;
    logic [xdbt_pkg::HashW-1:0] xor_dist;
    int unsigned      b;
    int unsigned      fill;
    int               hit;
    r = '0;
    r.status = xdbt_pkg::StIgnored;
    if (h == own_hash_q) return r;
    xor_dist = h ^ own_hash_q;
    b = Buckets - 1;
    for (int j = Buckets - 1; j >= 0; j--) begin
      if (xor_dist[Buckets-1-j]) b = j;
    end
    r.bucket_index = b[xdbt_pkg::IdxW-1:0];
    fill = (fill_cnt[b] > Slots) ? Slots : fill_cnt[b];
    hit = -1;
    for (int s = 0; s < fill; s++) begin
      if (hit < 0 && slot_hash[b][s] == h && slot_addr[b][s] == a) hit = s;
    end
    if (hit >= 0) begin
      // Known node: slide the entries ahead of it back by one and put it in front.
      for (int s = hit; s > 0; s--) begin
        slot_hash[b][s] = slot_hash[b][s-1];
        slot_addr[b][s] = slot_addr[b][s-1];
      end
      r.status = xdbt_pkg::StMoved;
    end else begin
      if (fill >= Slots) begin
        r.status          = xdbt_pkg::StEvict;
        r.evicted_hash    = slot_hash[b][Slots-1];
        r.evicted_address = slot_addr[b][Slots-1];
        fill = Slots - 1;
      end else begin
        r.status = xdbt_pkg::StInsert;
      end
      for (int s = fill; s > 0; s--) begin
        slot_hash[b][s] = slot_hash[b][s-1];
        slot_addr[b][s] = slot_addr[b][s-1];
      end
      fill_cnt[b] = fill + 1;
    end
    slot_hash[b][0] = h;
    slot_addr[b][0] = a;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    route_result_t exp_r;
    route_result_t got_r;
    if (!rst_ni) begin
      own_hash_q = '0;
      for (int b = 0; b < Buckets; b++) fill_cnt[b] = 0;
      expected_routes.delete();
      fail_count = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) own_hash_q = cfg_data_i;
      if (s_axis_tvalid && s_axis_tready) begin
        expected_routes.push_back(add_node(s_axis_tdata[63:0], s_axis_tdata[111:64]));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got_r = m_axis_tdata;
        if (expected_routes.size() == 0) begin
          $display("%0t: unexpected result word %h", $time, m_axis_tdata);
          fail_count++;
        end else begin
          exp_r = expected_routes.pop_front();
          if (got_r.status != exp_r.status) begin
            $display("%0t: status expected %0d got %0d", $time, exp_r.status, got_r.status);
            fail_count++;
          end
          if (got_r.bucket_index != exp_r.bucket_index) begin
            $display("%0t: bucket_index expected %0d got %0d", $time,
                     exp_r.bucket_index, got_r.bucket_index);
            fail_count++;
          end
          if (got_r.evicted_hash != exp_r.evicted_hash) begin
            $display("%0t: evicted_hash expected %h got %h", $time,
                     exp_r.evicted_hash, got_r.evicted_hash);
            fail_count++;
          end
          if (got_r.evicted_address != exp_r.evicted_address) begin
            $display("%0t: evicted_address expected %h got %h", $time,
                     exp_r.evicted_address, got_r.evicted_address);
            fail_count++;
          end
        end
      end
    end
  end
endmodule

>>> verif/tb_top.sv
// Top of the bucket table testbench: clock, reset, node stimulus, config writes and verdict.
// Depends on xdbt_pkg, route_table_checker and the xor_distance_bucket_table RTL.
`timescale 1ns / 1ps
module tb_top;
  localparam int CycleLimit  = 600000;
  localparam int DrainCycles = 40;

  logic         clk_i;
  logic         rst_ni;
  logic         cfg_valid_i;
  logic         cfg_ready_o;
  logic [63:0]  cfg_data_i;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  // node_hash[63:0], node_address[111:64]
  logic [111:0] s_axis_tdata;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  // status[1:0], bucket_index[7:2], evicted_hash[71:8], evicted_address[119:72]
  logic [119:0] m_axis_tdata;
  int           fail_count;
  int           pending;
  int           send_idle_pct;
  int           recv_stall_pct;
  int           cycle_count;
  logic [63:0]  own_hash;
  logic [63:0]  hash_pool [12];
  logic [47:0]  addr_pool [4];

  xor_distance_bucket_table DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  route_table_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // The receiver decides at each falling edge whether to take the result word.
  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Watchdog: a hang anywhere ends the run as a failure.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Offers one node word, with random idle cycles in front, and returns at the
  // falling edge after it was accepted. Valid stays high into the next word.
  task automatic send_node(input logic [63:0] h, input logic [47:0] a);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {a, h};
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  // Holds the sender off until every result has come back, lets the block
  // settle, and then writes a new own hash.
  task automatic write_own_hash(input logic [63:0] value);
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    own_hash = value;
  endtask

  // Builds a node that mostly lands in a chosen bucket and comes from a small pool,
  // so that buckets fill up, entries move to the front and tails get evicted.
  task automatic send_random_node();
    logic [63:0] h;
    logic [63:0] below;
    logic [47:0] a;
    int          b;
    int          pick;
    pick = $urandom_range(99);
    if (pick < 5) begin
      h = own_hash;
    end else if (pick < 15) begin
      h = {$urandom, $urandom};
    end else begin
      // Favor deep buckets: they are the ones that a table really exercises.
      b = ($urandom_range(1)) ? $urandom_range(63, 48) : $urandom_range(63);
      below = (b == 63) ? 64'd0 : ((64'd1 << (63 - b)) - 64'd1);
      h = own_hash ^ (64'd1 << (63 - b)) ^ (hash_pool[$urandom_range(11)] & below);
    end
    a = ($urandom_range(99) < 20) ? 48'({$urandom, $urandom}) : addr_pool[$urandom_range(3)];
    send_node(h, a);
  endtask

  initial begin
    rst_ni         = 1'b0;
    cfg_valid_i    = 1'b0;
    cfg_data_i     = '0;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    m_axis_tready  = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    cycle_count    = 0;
    own_hash       = '0;
    for (int i = 0; i < 12; i++) hash_pool[i] = {$urandom, $urandom};
    for (int i = 0; i < 4; i++) addr_pool[i] = 48'({$urandom, $urandom});
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed part with the reset own hash of zero.
    send_node('0, '1);                  // own hash is ignored
    send_node('1, '1);                  // all-ones hash goes to the first bucket
    send_node('1, '1);                  // same node again moves to the front
    send_node('1, '0);                  // same hash, other address is a new node
    // Hash one differs only in the last bit: fill the last bucket past capacity.
    for (int k = 0; k < 10; k++) send_node(64'd1, 48'(k));
    send_node(64'd1, 48'd5);            // a middle entry moves to the front
    send_node(64'd1, 48'd2);            // the oldest survivor moves up too
    send_node({1'b0, {63{1'b1}}}, '1);  // second bucket
    send_node(64'h8000_0000_0000_0000, 48'hFFFF_FFFF_FFFF);

    // Several own hashes, the extremes among them, with three idling profiles.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: write_own_hash('1);
        1: write_own_hash({$urandom, $urandom});
        2: write_own_hash({$urandom, $urandom});
        default: write_own_hash('0);
      endcase
      case (phase)
        0: begin
          send_idle_pct  = 34;
          recv_stall_pct = 70;
        end
        1: begin
          send_idle_pct  = 70;
          recv_stall_pct = 34;
        end
        default: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
      endcase
      repeat (475) send_random_node();
    end
    s_axis_tvalid <= 1'b0;

    while (pending != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule

>>> xor_distance_bucket_table.f
hw/rtl/xdbt_pkg.sv
hw/rtl/xor_distance_bucket_table.sv
verif/route_table_checker.sv
verif/tb_top.sv
